[sv/bilinear_rgb_resampler_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear RGB resampler
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_RGB_RESAMPLER_CORE_ASSERT_SVH
`define BILINEAR_RGB_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication
`define BRR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/brr_pkg.sv]
// ---------------------------------------------------------------------------
// brr_pkg
// Types, register codes and the blend function of the bilinear resampler.
// ---------------------------------------------------------------------------
package brr_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_IN_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_IN_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_OUT_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_OUT_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_STEP_X     = 3'd4;
   localparam logic [2:0] CSR_STEP_Y     = 3'd5;

   // Reset values of the registers
   localparam logic [12:0] RST_IN_WIDTH   = 13'd640;
   localparam logic [12:0] RST_IN_HEIGHT  = 13'd480;
   localparam logic [11:0] RST_OUT_WIDTH  = 12'd256;
   localparam logic [12:0] RST_OUT_HEIGHT = 13'd256;
   localparam logic [28:0] RST_STEP_X     = 29'd163840;
   localparam logic [28:0] RST_STEP_Y     = 29'd122880;

   // Output row limit and result cap per input pixel
   localparam logic [12:0] OUT_ROW_SPAN = 13'd4096;
   localparam logic [6:0]  MAX_RESULTS  = 7'd64;

   // Source positions are 25.16, wide enough for 4096 steps below 2^29
   localparam int POS_W = 41;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [12:0] in_width;
      logic [12:0] in_height;
      logic [11:0] out_width;
      logic [12:0] out_height;
      logic [28:0] step_x;
      logic [28:0] step_y;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL,
      ST_HMIX,
      ST_ROW,
      ST_FLUSH,
      ST_END,
      ST_ADV
   } state_type;

   typedef struct packed {
      logic load;
      logic col_read;
      logic hmix;
      logic row_emit;
      logic col_next;
      logic flush;
      logic adv;
      logic step_end;
   } cmd_type;

   typedef struct packed {
      logic col_go;
      logic row_go;
      logic p_valid;
      logic o_free;
      logic n_full;
      logic need_adv;
      logic adv_more;
   } status_type;

   // Blend two RGB pixels: (a*(0x10000-frac) + b*frac) >> 16 per component
   function automatic logic [23:0] mix(input logic [23:0] a, input logic [23:0] b,
                                       input logic [15:0] frac);
      logic [16:0] l1;
      logic [16:0] l2;
      logic [24:0] sum;
      logic [23:0] res;
      l2 = {1'b0, frac};
      l1 = 17'h10000 - l2;
      res = '0;
      for (int s = 0; s < 3; s++) begin
         sum = 25'(a[s*8 +: 8] * l1) + 25'(b[s*8 +: 8] * l2);
         res[s*8 +: 8] = sum[23:16];
      end
      return res;
   endfunction

endpackage

[sv/brr_ram.sv]
// ---------------------------------------------------------------------------
// brr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module brr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read port with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/brr_ctrl.sv]
// ---------------------------------------------------------------------------
// brr_ctrl
// Sequencer of the resampler: walks columns, rows and the row advance.
// ---------------------------------------------------------------------------
module brr_ctrl import brr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            if (status.col_go) begin
               cmd.col_read = 1'b1;
               state_in     = ST_HMIX;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_HMIX: begin
            cmd.hmix = 1'b1;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (status.row_go) begin
               // hold while the pending result cannot move out
               if (status.n_full || !status.p_valid || status.o_free) begin
                  cmd.row_emit = 1'b1;
               end
            end else begin
               cmd.col_next = 1'b1;
               state_in     = ST_COL;
            end
         end
         ST_FLUSH: begin
            if (!status.p_valid) begin
               state_in = ST_END;
            end else if (status.o_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_END;
            end
         end
         ST_END: begin
            if (status.need_adv) begin
               state_in = ST_ADV;
            end else begin
               cmd.step_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ADV: begin
            if (status.adv_more) begin
               cmd.adv = 1'b1;
            end else begin
               cmd.step_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/brr_datapath.sv]
// ---------------------------------------------------------------------------
// brr_datapath
// Counters, positions, blends, line store and result registers.
// ---------------------------------------------------------------------------
module brr_datapath import brr_pkg::*; #(
   parameter int MAX_OUT_WIDTH = 2048,
   parameter int MAX_IN_SIDE   = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int CW = $clog2(MAX_IN_SIDE);
   localparam int JW = $clog2(MAX_OUT_WIDTH);
   localparam int SW = (CW + 1 > 13) ? CW + 1 : 13;
   localparam int XW = POS_W - 16;

   // Effective sizes
   logic [SW-1:0] w_ext;
   logic [SW-1:0] h_ext;
   logic [CW-1:0] endx;
   logic [CW-1:0] endy;
   logic [11:0]   ow;
   logic [12:0]   oh;

   always_comb begin
      w_ext = SW'(cfg.in_width);
      h_ext = SW'(cfg.in_height);
      if (w_ext == '0) begin
         endx = '0;
      end else if (w_ext > SW'(MAX_IN_SIDE)) begin
         endx = CW'(MAX_IN_SIDE - 1);
      end else begin
         endx = CW'(w_ext - 1'b1);
      end
      if (h_ext == '0) begin
         endy = '0;
      end else if (h_ext > SW'(MAX_IN_SIDE)) begin
         endy = CW'(MAX_IN_SIDE - 1);
      end else begin
         endy = CW'(h_ext - 1'b1);
      end
      ow = (14'(cfg.out_width) > 14'(MAX_OUT_WIDTH)) ? 12'(MAX_OUT_WIDTH) : cfg.out_width;
      oh = (cfg.out_height > OUT_ROW_SPAN) ? OUT_ROW_SPAN : cfg.out_height;
   end

   // Stream state
   logic [23:0]      prev_ff;
   logic [23:0]      cur_ff;
   logic [CW-1:0]    in_col_ff;
   logic [CW-1:0]    in_row_ff;
   logic [11:0]      next_col_ff;
   logic [12:0]      next_row_ff;
   logic [POS_W-1:0] col_pos_ff;
   logic [POS_W-1:0] row_pos_ff;

   // Per-column working registers
   logic [23:0]      hv_ff;
   logic [23:0]      line_ff;
   logic [12:0]      rr_ff;
   logic [POS_W-1:0] rp_ff;
   logic [6:0]       n_ff;

   // Pending and output results
   rsp_type p_data_ff;
   logic    p_valid_ff;
   rsp_type o_data_ff;
   logic    o_valid_ff;

   logic [23:0] ram_rd;
   logic [XW-1:0] xi;
   logic [XW-1:0] yi;
   logic col_blend;
   logic col_copy;
   logic row_blend;
   logic row_copy;
   logic c_at_end;
   logic r_at_end;
   logic o_free;
   logic produce;
   logic o_load;
   logic [23:0] vpix;
   rsp_type new_rsp;
   rsp_type o_next;

   // Column and row decisions
   always_comb begin
      xi        = col_pos_ff[POS_W-1:16];
      yi        = rp_ff[POS_W-1:16];
      c_at_end  = (in_col_ff >= endx);
      r_at_end  = (in_row_ff >= endy);
      col_blend = (in_col_ff != '0) && (xi == XW'(in_col_ff - 1'b1)) && (xi < XW'(endx));
      col_copy  = c_at_end;
      row_blend = (in_row_ff != '0) && (yi == XW'(in_row_ff - 1'b1)) && (yi < XW'(endy));
      row_copy  = r_at_end;
      o_free    = !o_valid_ff || rsp_ready;
      vpix      = row_blend ? mix(line_ff, hv_ff, rp_ff[15:0]) : hv_ff;
      produce   = cmd.row_emit && !n_ff[6];
      o_load    = (produce && p_valid_ff) || cmd.flush;
      new_rsp.out_red   = vpix[23:16];
      new_rsp.out_green = vpix[15:8];
      new_rsp.out_blue  = vpix[7:0];
      new_rsp.out_row   = rr_ff[11:0];
      new_rsp.out_col   = next_col_ff[10:0];
      new_rsp.run_last  = 1'b0;
      o_next            = p_data_ff;
      o_next.run_last   = cmd.flush;
   end

   assign status.col_go   = (next_col_ff < ow) && (col_blend || col_copy);
   assign status.row_go   = (rr_ff < oh) && (row_blend || row_copy);
   assign status.p_valid  = p_valid_ff;
   assign status.o_free   = o_free;
   assign status.n_full   = (n_ff >= MAX_RESULTS);
   assign status.need_adv = c_at_end && !r_at_end;
   assign status.adv_more = (next_row_ff < oh) && (row_pos_ff[POS_W-1:16] < XW'(in_row_ff));

   // Line store of horizontally blended pixels
   brr_ram #(
      .WIDTH (24),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (cmd.col_next),
      .wr_addr (JW'(next_col_ff)),
      .wr_data (hv_ff),
      .rd_en   (cmd.col_read),
      .rd_addr (JW'(next_col_ff)),
      .rd_data (ram_rd)
   );

   // Stream counters and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         next_col_ff <= '0;
         next_row_ff <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         n_ff        <= '0;
      end else begin
         if (cmd.load) begin
            n_ff <= '0;
         end else if (produce) begin
            n_ff <= n_ff + 1'b1;
         end
         if (cmd.col_next) begin
            next_col_ff <= next_col_ff + 1'b1;
            col_pos_ff  <= col_pos_ff + POS_W'(cfg.step_x);
         end
         if (cmd.adv) begin
            next_row_ff <= next_row_ff + 1'b1;
            row_pos_ff  <= row_pos_ff + POS_W'(cfg.step_y);
         end
         if (cmd.step_end) begin
            prev_ff <= cur_ff;
            if (c_at_end) begin
               in_col_ff   <= '0;
               next_col_ff <= '0;
               col_pos_ff  <= '0;
               if (r_at_end) begin
                  in_row_ff   <= '0;
                  next_row_ff <= '0;
                  row_pos_ff  <= '0;
               end else begin
                  in_row_ff <= in_row_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
      end
   end

   // Working registers for one column
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= {req_data.red, req_data.green, req_data.blue};
      end
      if (cmd.hmix) begin
         hv_ff   <= col_blend ? mix(prev_ff, cur_ff, col_pos_ff[15:0]) : cur_ff;
         line_ff <= ram_rd;
         rr_ff   <= next_row_ff;
         rp_ff   <= row_pos_ff;
      end
      if (cmd.row_emit) begin
         rr_ff <= rr_ff + 1'b1;
         rp_ff <= rp_ff + POS_W'(cfg.step_y);
      end
   end

   // Pending result and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (produce) begin
            p_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            p_valid_ff <= 1'b0;
         end
         if (o_load) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         p_data_ff <= new_rsp;
      end
      if (o_load) begin
         o_data_ff <= o_next;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule

[sv/bilinear_rgb_resampler_core.sv]
// ---------------------------------------------------------------------------
// bilinear_rgb_resampler_core
// Streaming bilinear RGB resizer, 25.16 fixed-point positions, with a line store.
// ---------------------------------------------------------------------------
// Source pixels enter on req_ (valid/ready) in raster order, one per transfer.
// Each pixel releases zero or more resampled pixels on rsp_, each tagged with
// its output row and column; run_last marks the last one of that pixel.
// Registers are written on csr_ (index, data) in the cycle offered; the user
// writes them only while the block is idle; the block does not enforce it.
// Steps per source pixel, handled one at a time by the sequencer:
//   accept; per output column finished, line store read, horizontal blend
//   and column close, plus a last column check; a vertical blend per result;
//   flush; end; and at a source row end a row advance per output row
//   skipped, then a final step.
// A result reaches rsp_valid in the cycle after the following result or the
// flush; a stalled receiver holds the sequencer once both the pending and
// the output register are full.
// Reset clears the counters, the previous pixel and all valid flags and
// restores the register defaults; the line store needs no clearing since its
// data is only used for a vertical blend, from the second source row on.

`include "bilinear_rgb_resampler_core_assert.svh"

module bilinear_rgb_resampler_core import brr_pkg::*; #(
   parameter int MAX_OUT_WIDTH = 2048,
   parameter int MAX_IN_SIDE   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [28:0] csr_data
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width   <= RST_IN_WIDTH;
         cfg_ff.in_height  <= RST_IN_HEIGHT;
         cfg_ff.out_width  <= RST_OUT_WIDTH;
         cfg_ff.out_height <= RST_OUT_HEIGHT;
         cfg_ff.step_x     <= RST_STEP_X;
         cfg_ff.step_y     <= RST_STEP_Y;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IN_WIDTH:   cfg_ff.in_width   <= csr_data[12:0];
            CSR_IN_HEIGHT:  cfg_ff.in_height  <= csr_data[12:0];
            CSR_OUT_WIDTH:  cfg_ff.out_width  <= csr_data[11:0];
            CSR_OUT_HEIGHT: cfg_ff.out_height <= csr_data[12:0];
            CSR_STEP_X:     cfg_ff.step_x     <= csr_data;
            CSR_STEP_Y:     cfg_ff.step_y     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   brr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brr_datapath #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_IN_SIDE   (MAX_IN_SIDE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // One pixel at a time: no second transfer right after one
   `BRR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "pixel accepted while busy")
   // Nothing left pending when a new pixel can enter
   `BRR_ASSERT_IMPLIES(a_idle_drained, clock, reset, req_ready, !status.p_valid, "pending result at idle")
   // A flush only moves into a free output register
   `BRR_ASSERT_IMPLIES(a_flush_free, clock, reset, cmd.flush, status.o_free && status.p_valid, "flush into busy output")

endmodule
